[sv/acc_pkg.sv]
// package: operation and status codes, control types and sizes for the accumulator
`timescale 1ns / 1ps
package acc_pkg;

  // number of history entries held
  localparam int HISTORY_DEPTH = 16;
  // width of the entry count, which runs 1 .. HISTORY_DEPTH
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int DATA_W = 32;

  // operation codes carried in func; 6 and 7 are invalid
  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_MUL   = 3'd2,
    FN_DIV   = 3'd3,
    FN_UNDO  = 3'd4,
    FN_CLEAR = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_DIVZERO = 2'd1,
    STS_NOUNDO  = 2'd2,
    STS_INVALID = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_t;

  // shift control shared by every history cell
  typedef struct packed {
    logic shift_dn;  // push: take the value from the newer neighbor
    logic shift_up;  // pop: take the value from the older neighbor
  } stk_ctl_t;

endpackage

[sv/acc_cell.sv]
// one history cell: holds an entry and shifts with its neighbors on push and pop
`timescale 1ns / 1ps
module acc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acc_pkg::stk_ctl_t        ctl,
  input  logic [acc_pkg::DATA_W-1:0] newer_val,
  input  logic [acc_pkg::DATA_W-1:0] older_val,
  output logic [acc_pkg::DATA_W-1:0] val
);
  import acc_pkg::*;

  logic [DATA_W-1:0] val_r;

  // entry register, zero after reset so the newest cell starts as the zero base entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (ctl.shift_dn) begin
      val_r <= newer_val;
    end else if (ctl.shift_up) begin
      val_r <= older_val;
    end
  end

  assign val = val_r;

endmodule

[sv/acc_div.sv]
// iterative radix-2 signed divider, quotient truncated toward zero, one bit per cycle
`timescale 1ns / 1ps
module acc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [acc_pkg::DATA_W-1:0] dividend,
  input  logic [acc_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [acc_pkg::DATA_W-1:0] quotient
);
  import acc_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  // operand magnitudes
  assign mag_a = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};

  // control: run for DATA_W steps, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DATA_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: restoring division, quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (run_r) begin
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

[sv/accumulator_with_undo_stack.sv]
// top level: accumulator with a bounded undo history built as a row of shifting cells
`timescale 1ns / 1ps
// Signed 32-bit accumulator. Each input transaction carries an operation and an
// operand and gives exactly one output transaction with the new total and a status.
// One transaction is worked on at a time. Add, subtract, multiply, undo, clear,
// the invalid codes and a divide by zero go from acceptance to the write-back state,
// which loads the result into the output register and opens the input again; a
// divide first waits in the divide state for the one-bit-per-cycle divider (load,
// 32 steps, quotient capture), then goes to write-back.
// The history is a row of HISTORY_DEPTH cells, newest first: a push shifts every
// cell one place toward the old end (the oldest falls off), an undo shifts back.
// The output register holds a result until taken while the next transaction
// is already being accepted and computed.
module accumulator_with_undo_stack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_func,
  input  logic signed [acc_pkg::DATA_W-1:0] in_operand,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [acc_pkg::DATA_W-1:0] out_total,
  output logic [1:0]                 out_status
);
  import acc_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [2:0]        func_r;
  logic              divzero_r;
  logic [DATA_W-1:0] result_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_total_r;
  status_t           out_status_r;

  logic              accept;
  logic              out_free;
  logic              wb_fire;
  logic              do_push;
  logic              do_pop;
  logic              do_clear;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic [DATA_W-1:0] top_in;
  logic [DATA_W-1:0] wb_total;
  status_t           wb_status;
  stk_ctl_t          stk_ctl;
  logic [DATA_W-1:0] cell_val [HISTORY_DEPTH];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign div_start = accept && (in_func == FN_DIV) && (in_operand != '0);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and write-back decode
  always_comb begin
    state_nxt = state_r;
    wb_fire   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end else if (accept) begin
          state_nxt = ST_WB;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          wb_fire   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // latch the operation, compute the add, subtract and multiply results and capture the divide quotient
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_func;
      divzero_r <= (in_operand == '0);
      case (in_func)
        FN_ADD:  result_r <= cell_val[0] + in_operand;
        FN_SUB:  result_r <= cell_val[0] - in_operand;
        FN_MUL:  result_r <= cell_val[0] * in_operand;
        default: result_r <= cell_val[0];
      endcase
    end else if (div_done) begin
      result_r <= div_q;
    end
  end

  // stack actions, total and status for the finished transaction
  always_comb begin
    do_push   = 1'b0;
    do_pop    = 1'b0;
    do_clear  = 1'b0;
    wb_total  = cell_val[0];
    wb_status = STS_OK;
    case (func_r)
      FN_ADD, FN_SUB, FN_MUL: begin
        do_push  = wb_fire;
        wb_total = result_r;
      end
      FN_DIV: begin
        if (divzero_r) begin
          wb_status = STS_DIVZERO;
        end else begin
          do_push  = wb_fire;
          wb_total = result_r;
        end
      end
      FN_UNDO: begin
        if (cnt_r <= CNT_W'(1)) begin
          wb_status = STS_NOUNDO;
        end else begin
          do_pop   = wb_fire;
          wb_total = cell_val[1];
        end
      end
      FN_CLEAR: begin
        do_clear = wb_fire;
        wb_total = '0;
      end
      default: wb_status = STS_INVALID;
    endcase
  end

  // clear pushes a zero and drops the count back to the base entry
  assign stk_ctl.shift_dn = do_push || do_clear;
  assign stk_ctl.shift_up = do_pop;
  assign top_in           = do_clear ? '0 : result_r;

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(1);
    end else if (do_clear) begin
      cnt_r <= CNT_W'(1);
    end else if (do_push) begin
      if (cnt_r < CNT_W'(HISTORY_DEPTH)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (do_pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // history cells, newest at index zero
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] newer;
    logic [DATA_W-1:0] older;
    if (i == 0) begin : g_first
      assign newer = top_in;
    end else begin : g_rest
      assign newer = cell_val[i-1];
    end
    if (i == HISTORY_DEPTH - 1) begin : g_last
      assign older = '0;
    end else begin : g_mid
      assign older = cell_val[i+1];
    end
    acc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (stk_ctl),
      .newer_val (newer),
      .older_val (older),
      .val       (cell_val[i])
    );
  end

  // divider
  acc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cell_val[0]),
    .divisor  (in_operand),
    .done     (div_done),
    .quotient (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_total_r  <= wb_total;
      out_status_r <= wb_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_total  = out_total_r;
  assign out_status = out_status_r;

endmodule

[sv/acc_chk.sv]
// port-level checker for the accumulator, bound to the top level
`timescale 1ns / 1ps
module acc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [2:0]                 in_func,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [acc_pkg::DATA_W-1:0] out_total,
  input logic [1:0]                 out_status
);
  import acc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total) && $stable(out_status))
    else $error("stalled result changed");

  // one transaction at a time: input closes after an accept
  a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // nothing presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a non-divide transaction into an empty output is shown after write-back
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func != FN_DIV) && !out_valid |=> ##1 out_valid)
    else $error("fast transaction result missing");

  // an add into an empty output reports an OK status
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FN_ADD) && !out_valid
      |=> ##1 (out_status == STS_OK))
    else $error("add reported an error status");

endmodule

bind accumulator_with_undo_stack acc_chk u_acc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_func    (in_func),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_total  (out_total),
  .out_status (out_status)
);

[tb/accumulator_with_undo_stack_chk.sv]
// checker: predicts the accumulator results and compares each output transaction
`timescale 1ns / 1ps
module accumulator_with_undo_stack_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [2:0]                        in_func,
  input  logic signed [acc_pkg::DATA_W-1:0] in_operand,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [acc_pkg::DATA_W-1:0] out_total,
  input  logic [1:0]                        out_status,
  output int                                fail_count,
  output int                                exp_left
);
  import acc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    status_t           status;
  } acc_result_t;

  // predicted accumulator state, history newest first
  logic [DATA_W-1:0] hist [HISTORY_DEPTH];
  int                held;
  logic [DATA_W-1:0] acc_total;

  acc_result_t totals_due[$];
  int          n_checked;

  initial begin
    fail_count = 0;
    exp_left   = 0;
    n_checked  = 0;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    fail_count++;
    $display("%0t: mismatch on result %0d, %s: got %0d, expected %0d", $realtime,
             n_checked, what, $signed(got), $signed(want));
  endtask

  // signed division truncating toward zero, min / -1 wraps to min
  function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] a,
                                                       input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb, q;
    ma = a[DATA_W-1] ? ('0 - a) : a;
    mb = b[DATA_W-1] ? ('0 - b) : b;
    q  = ma / mb;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? ('0 - q) : q;
  endfunction

  // push a new total, oldest entry falls off when full
  task automatic push_total(input logic [DATA_W-1:0] v);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = v;
    if (held < HISTORY_DEPTH) held++;
    acc_total = v;
  endtask

  task automatic clear_history();
    hist[0]   = '0;
    held      = 1;
    acc_total = '0;
  endtask

  // next state and expected result for one input transaction
  task automatic apply_transaction(input logic [2:0] fn, input logic [DATA_W-1:0] opd,
                                   output acc_result_t r);
    r.status = STS_OK;
    case (fn)
      FN_ADD: push_total(acc_total + opd);
      FN_SUB: push_total(acc_total - opd);
      FN_MUL: push_total(acc_total * opd);
      FN_DIV: begin
        if (opd == '0) r.status = STS_DIVZERO;
        else push_total(trunc_quotient(acc_total, opd));
      end
      FN_UNDO: begin
        if (held <= 1) begin
          r.status = STS_NOUNDO;
        end else begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist[i] = hist[i+1];
          held--;
          acc_total = hist[0];
        end
      end
      FN_CLEAR: clear_history();
      default: r.status = STS_INVALID;
    endcase
    r.total = acc_total;
  endtask

  // watch both channels, results first since a new input cannot have its result yet
  always @(posedge clk) begin : watch
    acc_result_t e;
    acc_result_t r;
    if (!rst_n) begin
      clear_history();
      totals_due.delete();
      exp_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (totals_due.size() == 0) begin
          report_mismatch("result with no transaction waiting", out_total, 'x);
        end else begin
          e = totals_due.pop_front();
          if (out_total !== e.total) report_mismatch("total", out_total, e.total);
          if (out_status !== e.status)
            report_mismatch("status", DATA_W'(out_status), DATA_W'(e.status));
        end
        n_checked++;
      end
      if (in_valid && !in_stall) begin
        apply_transaction(in_func, in_operand, r);
        totals_due.push_back(r);
      end
      exp_left <= totals_due.size();
    end
  end

endmodule

[tb/accumulator_with_undo_stack_tb.sv]
// testbench top: clock, reset, stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps
module accumulator_with_undo_stack_tb;
  import acc_pkg::*;

  localparam int          N_ITEMS    = 1550;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          HOLD_CYC   = 300;
  localparam int          DRAIN_CYC  = 40;
  // codes outside the operation set
  localparam logic [2:0]  FN_BAD_LO  = 3'd6;
  localparam logic [2:0]  FN_BAD_HI  = 3'd7;
  localparam logic [31:0] MIN_VAL    = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL    = 32'h7fff_ffff;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_func;
  logic signed [DATA_W-1:0] in_operand;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_total;
  logic [1:0]               out_status;
  int                       fail_count;
  int                       exp_left;

  // shared pacing controls
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;
  int n_items     = 0;
  int idle_cycles = 0;

  accumulator_with_undo_stack i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_operand (in_operand),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_total  (out_total),
    .out_status (out_status)
  );

  accumulator_with_undo_stack_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_operand (in_operand),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_total  (out_total),
    .out_status (out_status),
    .fail_count (fail_count),
    .exp_left   (exp_left)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_operand();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom_range(0, 16);
      if ($urandom_range(0, 1)) v = '0 - v;
    end else if (r < 60) begin
      v = $urandom();
    end else if (r < 75) begin
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = 32'd1;
        2: v = '1;
        3: v = MIN_VAL;
        4: v = MAX_VAL;
        default: v = MIN_VAL + 1;
      endcase
    end else if (r < 90) begin
      v = $urandom_range(0, 2000) - 1000;
    end else begin
      v = 32'd1 << $urandom_range(0, 31);
    end
    return v;
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return FN_ADD;
    if (r < 40) return FN_SUB;
    if (r < 50) return FN_MUL;
    if (r < 62) return FN_DIV;
    if (r < 88) return FN_UNDO;
    if (r < 92) return FN_CLEAR;
    return 3'($urandom_range(FN_BAD_LO, FN_BAD_HI));
  endfunction

  // offer one transaction and wait until it is taken, then maybe idle
  task automatic offer(input logic [2:0] f, input logic [31:0] opd);
    int gap;
    in_func    <= f;
    in_operand <= opd;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f <= FN_CLEAR) n_items++;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every result has come back
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_left != 0) @(posedge clk);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic press_block();
    drain_wait();
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    tx_calm = 1'b1;
    repeat (12) offer(pick_func(), pick_operand());
    tx_calm = 1'b0;
  endtask

  // output side stalls
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int         kind;
    int         len;
    logic [2:0] f;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_func    <= FN_ADD;
    in_operand <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: undo at the base, wraps, min / -1, divide by zero, invalid codes
    offer(FN_UNDO, 32'h1234_5678);
    offer(FN_ADD, MAX_VAL);
    offer(FN_ADD, 32'd1);
    offer(FN_DIV, '1);
    offer(FN_DIV, '0);
    offer(FN_SUB, 32'd1);
    offer(FN_MUL, '1);
    offer(FN_BAD_LO, '1);
    offer(FN_BAD_HI, '0);
    offer(FN_UNDO, '1);
    offer(FN_CLEAR, 32'hdead_beef);
    // truncation toward zero on negative totals and divisors
    offer(FN_SUB, 32'd7);
    offer(FN_DIV, 32'd2);
    offer(FN_DIV, '0 - 32'd2);
    offer(FN_MUL, MIN_VAL);
    offer(FN_DIV, MIN_VAL);
    // undo all the way back to the base and once past it
    repeat (6) offer(FN_UNDO, $urandom());

    press_block();

    // random bursts shaped to fill the history and unwind it
    while (n_items < N_ITEMS) begin
      kind    = $urandom_range(0, 99);
      tx_calm = ($urandom_range(0, 7) == 0);
      rx_calm = tx_calm;
      if (kind < 35) begin
        len = $urandom_range(1, 24);
        repeat (len) begin
          f = 3'($urandom_range(FN_ADD, FN_DIV));
          offer(f, pick_operand());
        end
      end else if (kind < 60) begin
        len = $urandom_range(1, 20);
        repeat (len) offer(FN_UNDO, $urandom());
      end else if (kind < 85) begin
        len = $urandom_range(1, 16);
        repeat (len) offer(pick_func(), pick_operand());
      end else if (kind < 93) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          f = 3'($urandom_range(0, 7));
          offer(f, $urandom());
        end
      end else if (kind < 96) begin
        offer(FN_CLEAR, $urandom());
      end else if (kind < 98) begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        press_block();
      end else begin
        drain_wait();
      end
    end

    // let every result drain, then keep watching for stray output
    tx_calm = 1'b0;
    rx_calm = 1'b1;
    drain_wait();
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
